// File: sv/kwb_pkg.sv
// Shared types, codes and widths of the keyed warning board.
`default_nettype none

package kwb_pkg;

    // Default geometry
    localparam int MAX_ENTRIES_DEF = 8;
    localparam int KEY_BITS_DEF    = 32;

    // Fixed field widths
    localparam int KEY_W    = 32;
    localparam int SEV_W    = 2;
    localparam int MS_W     = 48;
    localparam int OCC_W    = 32;
    localparam int STAT_W   = 2;
    localparam int SLOT_W   = 4;
    localparam int ACTIVE_W = 4;

    // Depth of the command queue between front and back
    localparam int Q_DEPTH = 2;

    // Severity codes
    localparam logic [SEV_W-1:0] SEV_OK   = 2'd0;
    localparam logic [SEV_W-1:0] SEV_WARN = 2'd1;
    localparam logic [SEV_W-1:0] SEV_CRIT = 2'd2;

    typedef enum logic [STAT_W-1:0] {
        ST_OK            = 2'd0,
        ST_INVALID_STATE = 2'd1,
        ST_INVALID_ARG   = 2'd2,
        ST_NO_MEM        = 2'd3
    } t_status;

    // Command class decided by the front
    typedef enum logic [1:0] {
        OP_REJ_STATE = 2'd0,
        OP_REJ_ARG   = 2'd1,
        OP_CLEAR     = 2'd2,
        OP_SET       = 2'd3
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [KEY_W-1:0] key;
        logic [SEV_W-1:0] sev;
        logic [MS_W-1:0]  time_ms;
    } t_cmd;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_stat;

endpackage

`default_nettype wire

// File: sv/kwb_if.sv
// Channel interfaces: publish input, configuration write and result output.
`default_nettype none

interface kwb_in_if;
    import kwb_pkg::*;
    logic             valid;
    logic             ready;
    logic [KEY_W-1:0] source_key;
    logic [SEV_W-1:0] severity;
    logic [MS_W-1:0]  time_ms;
    modport source (output valid, source_key, severity, time_ms, input ready);
    modport sink   (input valid, source_key, severity, time_ms, output ready);
endinterface

interface kwb_cfg_if;
    logic valid;
    logic ready;
    logic board_enabled;
    modport source (output valid, board_enabled, input ready);
    modport sink   (input valid, board_enabled, output ready);
endinterface

interface kwb_out_if;
    import kwb_pkg::*;
    logic                valid;
    logic                ready;
    logic [STAT_W-1:0]   status;
    logic [SEV_W-1:0]    worst_level;
    logic [SLOT_W-1:0]   slot_index;
    logic [OCC_W-1:0]    occurrences;
    logic [MS_W-1:0]     first_seen_ms;
    logic [ACTIVE_W-1:0] active_entries;
    logic [OCC_W-1:0]    dropped_total;
    modport source (output valid, status, worst_level, slot_index, occurrences,
                    first_seen_ms, active_entries, dropped_total, input ready);
    modport sink   (input valid, status, worst_level, slot_index, occurrences,
                    first_seen_ms, active_entries, dropped_total, output ready);
endinterface

`default_nettype wire

// File: sv/kwb_front.sv
// Front end: holds the enable register, accepts publish words and classifies them.
`default_nettype none

module kwb_front
    import kwb_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    kwb_in_if.sink       i_in,
    kwb_cfg_if.sink      i_cfg,
    input  wire t_q_stat i_q_stat,
    output logic         o_push,
    output t_cmd         o_cmd
);

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam logic [KEY_W-1:0] KEY_MASK = KEY_W'((64'd1 << KW) - 64'd1);

    logic             r_enabled;
    logic             n_enabled;
    logic [KEY_W-1:0] key_m;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_q_stat.full;
    assign o_push      = i_in.valid && i_in.ready;
    assign key_m       = i_in.source_key & KEY_MASK;

    always_comb begin
        n_enabled = r_enabled;
        if (i_cfg.valid) begin
            n_enabled = i_cfg.board_enabled;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
        end else begin
            r_enabled <= n_enabled;
        end
    end

    always_comb begin
        o_cmd.key     = key_m;
        o_cmd.sev     = i_in.severity;
        o_cmd.time_ms = i_in.time_ms;
        if (!r_enabled) begin
            o_cmd.op = OP_REJ_STATE;
        end else if (key_m == '0 || i_in.severity > SEV_CRIT) begin
            o_cmd.op = OP_REJ_ARG;
        end else if (i_in.severity == SEV_OK) begin
            o_cmd.op = OP_CLEAR;
        end else begin
            o_cmd.op = OP_SET;
        end
    end

endmodule

`default_nettype wire

// File: sv/kwb_queue.sv
// Short command queue between the front and the back.
`default_nettype none

module kwb_queue
    import kwb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_cmd i_cmd,
    input  wire logic i_pop,
    output t_cmd      o_head,
    output t_q_stat   o_stat
);

    localparam int QP_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QC_W = $clog2(Q_DEPTH + 1);

    t_cmd            r_buf [Q_DEPTH];
    logic [QP_W-1:0] r_wr, n_wr;
    logic [QP_W-1:0] r_rd, n_rd;
    logic [QC_W-1:0] r_cnt, n_cnt;

    assign o_head           = r_buf[r_rd];
    assign o_stat.not_empty = (r_cnt != '0);
    assign o_stat.full      = (r_cnt == QC_W'(Q_DEPTH));

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr  = (r_wr == QP_W'(Q_DEPTH - 1)) ? '0 : r_wr + QP_W'(1);
            n_cnt = n_cnt + QC_W'(1);
        end
        if (i_pop) begin
            n_rd  = (r_rd == QP_W'(Q_DEPTH - 1)) ? '0 : r_rd + QP_W'(1);
            n_cnt = n_cnt - QC_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// File: sv/kwb_back.sv
// Back end: warning table, key match, update or removal, and result register.
`default_nettype none

module kwb_back
    import kwb_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_cmd    i_head,
    input  wire t_q_stat i_q_stat,
    output logic         o_pop,
    kwb_out_if.source    o_out
);

    localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    typedef enum logic [1:0] {
        BS_FETCH = 2'b01,
        BS_APPLY = 2'b10
    } t_bstate;

    typedef struct packed {
        t_status             status;
        logic [SEV_W-1:0]    worst;
        logic [SLOT_W-1:0]   slot;
        logic [OCC_W-1:0]    occ;
        logic [MS_W-1:0]     first;
        logic [ACTIVE_W-1:0] active;
        logic [OCC_W-1:0]    dropped;
    } t_res;

    // Table rows; the last-seen time is not kept since no result reports it
    logic [KW-1:0]    r_key   [MAX_ENTRIES];
    logic [KW-1:0]    n_key   [MAX_ENTRIES];
    logic [SEV_W-1:0] r_lvl   [MAX_ENTRIES];
    logic [SEV_W-1:0] n_lvl   [MAX_ENTRIES];
    logic [OCC_W-1:0] r_cnt   [MAX_ENTRIES];
    logic [OCC_W-1:0] n_cnt   [MAX_ENTRIES];
    logic [MS_W-1:0]  r_first [MAX_ENTRIES];
    logic [MS_W-1:0]  n_first [MAX_ENTRIES];

    logic [CW-1:0]          r_used, n_used;
    logic [CW-1:0]          r_warn, n_warn;
    logic [CW-1:0]          r_crit, n_crit;
    logic [OCC_W-1:0]       r_drops, n_drops;
    t_bstate                r_state, n_state;
    logic                   r_out_valid, n_out_valid;
    t_cmd                   r_cmd, n_cmd;
    logic [MAX_ENTRIES-1:0] r_hit_vec, n_hit_vec;
    logic [CW-1:0]          r_idx, n_idx;
    t_res                   r_res, n_res;

    logic [MAX_ENTRIES-1:0] hit_vec;
    logic [CW-1:0]          hit_idx;
    logic [SEV_W-1:0]       sel_lvl;
    logic [OCC_W-1:0]       sel_cnt;
    logic [MS_W-1:0]        sel_first;
    logic                   r_hit;
    logic                   out_free;
    t_status                res_status;
    logic [CW-1:0]          res_slot;
    logic [OCC_W-1:0]       res_occ;
    logic [MS_W-1:0]        res_first;
    logic [SEV_W-1:0]       res_worst;

    assign o_pop    = (r_state == BS_FETCH) && i_q_stat.not_empty;
    assign r_hit    = |r_hit_vec;
    assign out_free = !r_out_valid || o_out.ready;

    // Match the queue head against every active row; keys are unique in the table
    always_comb begin
        hit_vec = '0;
        hit_idx = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_vec[i] = (CW'(i) < r_used) && (r_key[i] == i_head.key[KW-1:0]);
            if (hit_vec[i]) begin
                hit_idx = hit_idx | CW'(i);
            end
        end
    end

    // Pick the matched row's fields
    always_comb begin
        sel_lvl   = '0;
        sel_cnt   = '0;
        sel_first = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (r_hit_vec[i]) begin
                sel_lvl   = sel_lvl | r_lvl[i];
                sel_cnt   = sel_cnt | r_cnt[i];
                sel_first = sel_first | r_first[i];
            end
        end
    end

    always_comb begin
        n_key       = r_key;
        n_lvl       = r_lvl;
        n_cnt       = r_cnt;
        n_first     = r_first;
        n_used      = r_used;
        n_warn      = r_warn;
        n_crit      = r_crit;
        n_drops     = r_drops;
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_hit_vec   = r_hit_vec;
        n_idx       = r_idx;
        n_res       = r_res;
        n_out_valid = r_out_valid && !o_out.ready;
        res_status  = ST_OK;
        res_slot    = CW'(MAX_ENTRIES);
        res_occ     = '0;
        res_first   = '0;
        res_worst   = SEV_OK;
        case (r_state)
            BS_FETCH: begin
                if (i_q_stat.not_empty) begin
                    n_cmd     = i_head;
                    n_hit_vec = hit_vec;
                    n_idx     = hit_idx;
                    n_state   = BS_APPLY;
                end
            end
            BS_APPLY: begin
                if (out_free) begin
                    case (r_cmd.op)
                        OP_REJ_STATE: res_status = ST_INVALID_STATE;
                        OP_REJ_ARG:   res_status = ST_INVALID_ARG;
                        OP_CLEAR: begin
                            if (r_hit) begin
                                res_slot = r_idx;
                                // Shift later rows down over the removed one
                                for (int i = 0; i < MAX_ENTRIES - 1; i++) begin
                                    if (CW'(i) >= r_idx && CW'(i) + CW'(1) < r_used) begin
                                        n_key[i]   = r_key[i+1];
                                        n_lvl[i]   = r_lvl[i+1];
                                        n_cnt[i]   = r_cnt[i+1];
                                        n_first[i] = r_first[i+1];
                                    end
                                end
                                n_used = r_used - CW'(1);
                                if (sel_lvl == SEV_CRIT) begin
                                    n_crit = r_crit - CW'(1);
                                end else begin
                                    n_warn = r_warn - CW'(1);
                                end
                            end
                        end
                        OP_SET: begin
                            if (r_hit) begin
                                for (int i = 0; i < MAX_ENTRIES; i++) begin
                                    if (r_hit_vec[i]) begin
                                        n_lvl[i] = r_cmd.sev;
                                        n_cnt[i] = r_cnt[i] + OCC_W'(1);
                                    end
                                end
                                res_slot  = r_idx;
                                res_occ   = sel_cnt + OCC_W'(1);
                                res_first = sel_first;
                                if (sel_lvl == SEV_CRIT) begin
                                    n_crit = n_crit - CW'(1);
                                end else begin
                                    n_warn = n_warn - CW'(1);
                                end
                                if (r_cmd.sev == SEV_CRIT) begin
                                    n_crit = n_crit + CW'(1);
                                end else begin
                                    n_warn = n_warn + CW'(1);
                                end
                            end else if (r_used < CW'(MAX_ENTRIES)) begin
                                // Append at the end of the active rows
                                for (int i = 0; i < MAX_ENTRIES; i++) begin
                                    if (CW'(i) == r_used) begin
                                        n_key[i]   = r_cmd.key[KW-1:0];
                                        n_lvl[i]   = r_cmd.sev;
                                        n_cnt[i]   = OCC_W'(1);
                                        n_first[i] = r_cmd.time_ms;
                                    end
                                end
                                n_used    = r_used + CW'(1);
                                res_slot  = r_used;
                                res_occ   = OCC_W'(1);
                                res_first = r_cmd.time_ms;
                                if (r_cmd.sev == SEV_CRIT) begin
                                    n_crit = r_crit + CW'(1);
                                end else begin
                                    n_warn = r_warn + CW'(1);
                                end
                            end else begin
                                n_drops    = r_drops + OCC_W'(1);
                                res_status = ST_NO_MEM;
                            end
                        end
                        default: ;
                    endcase
                    if (n_crit != '0) begin
                        res_worst = SEV_CRIT;
                    end else if (n_warn != '0) begin
                        res_worst = SEV_WARN;
                    end
                    n_res.status  = res_status;
                    n_res.worst   = res_worst;
                    n_res.slot    = SLOT_W'(res_slot);
                    n_res.occ     = res_occ;
                    n_res.first   = res_first;
                    n_res.active  = ACTIVE_W'(n_used);
                    n_res.dropped = n_drops;
                    n_out_valid   = 1'b1;
                    n_state       = BS_FETCH;
                end
            end
            default: n_state = BS_FETCH;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used      <= '0;
            r_warn      <= '0;
            r_crit      <= '0;
            r_drops     <= '0;
            r_state     <= BS_FETCH;
            r_out_valid <= 1'b0;
        end else begin
            r_used      <= n_used;
            r_warn      <= n_warn;
            r_crit      <= n_crit;
            r_drops     <= n_drops;
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_lvl     <= n_lvl;
        r_cnt     <= n_cnt;
        r_first   <= n_first;
        r_cmd     <= n_cmd;
        r_hit_vec <= n_hit_vec;
        r_idx     <= n_idx;
        r_res     <= n_res;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.status         = r_res.status;
    assign o_out.worst_level    = r_res.worst;
    assign o_out.slot_index     = r_res.slot;
    assign o_out.occurrences    = r_res.occ;
    assign o_out.first_seen_ms  = r_res.first;
    assign o_out.active_entries = r_res.active;
    assign o_out.dropped_total  = r_res.dropped;

endmodule

`default_nettype wire

// File: sv/keyed_warning_board.sv
// Top level of the keyed warning board: front, command queue and back.
//
// The board keeps a table of up to MAX_ENTRIES active warnings, one row per
// source key, each with its level, occurrence count and first-seen time.
// Every publish word on i_in gives exactly one result word on o_out, in
// order. Severity warn or critical updates the matching row (count plus
// one) or appends a new row; severity ok removes the row and closes the gap.
// When the table is full the drop counter advances and no_mem is returned.
// With the board disabled every word returns invalid_state; an empty key
// (zero after keeping the low KEY_BITS bits) or severity code 3 returns
// invalid_arg. worst_level is the highest level left in the table after the
// word, tracked by per-level row counts. slot_index and active_entries show
// the low four bits of their values. Timing: the front takes one word per
// cycle into a two-word queue while the queue is not full; the back takes
// one word at a time, first matching the key against all rows, then, once
// the result register is free, applying the change and loading the result
// register. The result register frees the back as soon as o_out takes the
// word. Write i_cfg only while no word is in flight.
`default_nettype none

module keyed_warning_board
    import kwb_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int KEY_BITS    = KEY_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    kwb_in_if.sink    i_in,
    kwb_cfg_if.sink   i_cfg,
    kwb_out_if.source o_out
);

    logic    push;
    logic    pop;
    t_cmd    cmd;
    t_cmd    head;
    t_q_stat q_stat;

    // Classify each word and hold the enable bit
    kwb_front #(
        .KEY_BITS (KEY_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_in     (i_in),
        .i_cfg    (i_cfg),
        .i_q_stat (q_stat),
        .o_push   (push),
        .o_cmd    (cmd)
    );

    // Decouple accept from table work
    kwb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (q_stat)
    );

    // Match, update the table and present the result
    kwb_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .KEY_BITS    (KEY_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_head   (head),
        .i_q_stat (q_stat),
        .o_pop    (pop),
        .o_out    (o_out)
    );

endmodule

`default_nettype wire

// File: sv/kwb_checker.sv
// Port-level checks of the keyed warning board and their bind.
`default_nettype none

module kwb_checker
    import kwb_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input wire logic                i_clk,
    input wire logic                i_rst_n,
    input wire logic                i_valid,
    input wire logic                i_ready,
    input wire logic [STAT_W-1:0]   i_status,
    input wire logic [SEV_W-1:0]    i_worst,
    input wire logic [SLOT_W-1:0]   i_slot,
    input wire logic [OCC_W-1:0]    i_occ,
    input wire logic [MS_W-1:0]     i_first,
    input wire logic [ACTIVE_W-1:0] i_active,
    input wire logic [OCC_W-1:0]    i_dropped
);

    // A failed publish touches no row
    a_reject_no_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_status != ST_OK |->
            i_slot == SLOT_W'(MAX_ENTRIES) && i_occ == '0 && i_first == '0)
        else $error("failed publish reports a row");

    // A nonzero count only comes from a successful update or append
    a_occ_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_occ != '0 |-> i_status == ST_OK && i_worst != SEV_OK)
        else $error("count reported without an active row");

    // A warning level needs at least one active row
    a_worst_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_worst != SEV_OK |-> MAX_ENTRIES >= 16 || i_active != '0)
        else $error("worst level set on an empty table");

    // Hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_status) && $stable(i_occ)
            && $stable(i_active) && $stable(i_dropped))
        else $error("stalled result word changed");

endmodule

bind keyed_warning_board kwb_checker #(
    .MAX_ENTRIES (MAX_ENTRIES)
) u_kwb_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_out.valid),
    .i_ready   (o_out.ready),
    .i_status  (o_out.status),
    .i_worst   (o_out.worst_level),
    .i_slot    (o_out.slot_index),
    .i_occ     (o_out.occurrences),
    .i_first   (o_out.first_seen_ms),
    .i_active  (o_out.active_entries),
    .i_dropped (o_out.dropped_total)
);

`default_nettype wire

// File: sim/keyed_warning_board_tb.sv
// Self-checking testbench of the keyed warning board: directed table, then random words.
module keyed_warning_board_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import kwb_pkg::*;

    // Geometry of the instance under test and the codes the ports need
    localparam int BOARD_DEPTH = MAX_ENTRIES_DEF;
    localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(BOARD_DEPTH);
    localparam logic [SEV_W-1:0] SEV_BAD = 2'd3;    // code above critical, always rejected
    localparam int SETTLE_CYCLES = 8;               // extra wait once every result is back
    localparam int CYCLE_LIMIT = 300000;
    localparam int REPORT_MAX = 10;

    // One result word as it leaves the board
    typedef struct packed {
        t_status             status;
        logic [SEV_W-1:0]    worst;
        logic [SLOT_W-1:0]   slot;
        logic [OCC_W-1:0]    occ;
        logic [MS_W-1:0]     first;
        logic [ACTIVE_W-1:0] active;
        logic [OCC_W-1:0]    dropped;
    } t_board_result;

    // One row of the directed table: either a register write or a publish word,
    // with the result typed in where it is obvious
    typedef struct packed {
        bit               is_cfg;
        logic             enable;
        logic [KEY_W-1:0] key;
        logic [SEV_W-1:0] sev;
        logic [MS_W-1:0]  stamp;
        bit               pinned;
        t_board_result    res;
    } t_plan_row;

    logic clk = 1'b0;
    logic rst_n;

    kwb_in_if  in_ch ();
    kwb_cfg_if cfg_ch ();
    kwb_out_if out_ch ();

    keyed_warning_board i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // 12 ns period
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Shadow copy of the warning table kept by the predictor
    logic [KEY_W-1:0] tab_key   [BOARD_DEPTH];
    logic [SEV_W-1:0] tab_level [BOARD_DEPTH];
    logic [OCC_W-1:0] tab_count [BOARD_DEPTH];
    logic [MS_W-1:0]  tab_first [BOARD_DEPTH];
    logic [MS_W-1:0]  tab_last  [BOARD_DEPTH];
    int               tab_used = 0;
    logic [OCC_W-1:0] drop_cnt = '0;
    logic [SEV_W-1:0] worst_lvl = SEV_OK;
    logic             board_on = 1'b0;

    t_board_result awaited_results [$];
    t_plan_row     plan_q [$];

    // Typed expectation for the word currently offered, if the row has one
    bit            pin_valid = 1'b0;
    t_board_result pin_result;

    int cycle_count = 0;
    int err_count = 0;
    int words_in = 0;
    int words_out = 0;
    int tally_status [4] = '{0, 0, 0, 0};
    int sink_stall_pct = 0;

    // Apply one publish to the shadow table and return the result it must give
    function automatic t_board_result predict_publish(input logic [KEY_W-1:0] key,
                                                      input logic [SEV_W-1:0] sev,
                                                      input logic [MS_W-1:0] now);
        t_board_result r;
        int hit;
        int i;
        r.status = ST_OK;
        r.slot   = NO_SLOT;
        r.occ    = '0;
        r.first  = '0;
        hit      = -1;
        if (!board_on) begin
            r.status = ST_INVALID_STATE;
        end else if (key == '0 || sev == SEV_BAD) begin
            r.status = ST_INVALID_ARG;
        end else begin
            for (i = 0; i < tab_used; i++) begin
                if (hit < 0 && tab_key[i] == key) hit = i;
            end
            if (sev == SEV_OK) begin
                // clear: close the gap and zero the vacated tail row
                if (hit >= 0) begin
                    r.slot = hit[SLOT_W-1:0];
                    for (i = hit; i + 1 < tab_used; i++) begin
                        tab_key[i]   = tab_key[i+1];
                        tab_level[i] = tab_level[i+1];
                        tab_count[i] = tab_count[i+1];
                        tab_first[i] = tab_first[i+1];
                        tab_last[i]  = tab_last[i+1];
                    end
                    tab_used--;
                    tab_key[tab_used]   = '0;
                    tab_level[tab_used] = SEV_OK;
                    tab_count[tab_used] = '0;
                    tab_first[tab_used] = '0;
                    tab_last[tab_used]  = '0;
                end
            end else if (hit >= 0) begin
                tab_level[hit] = sev;
                tab_count[hit] = tab_count[hit] + 1'b1;
                tab_last[hit]  = now;
                r.slot  = hit[SLOT_W-1:0];
                r.occ   = tab_count[hit];
                r.first = tab_first[hit];
            end else if (tab_used < BOARD_DEPTH) begin
                tab_key[tab_used]   = key;
                tab_level[tab_used] = sev;
                tab_count[tab_used] = OCC_W'(1);
                tab_first[tab_used] = now;
                tab_last[tab_used]  = now;
                r.slot  = tab_used[SLOT_W-1:0];
                r.occ   = OCC_W'(1);
                r.first = now;
                tab_used++;
            end else begin
                drop_cnt = drop_cnt + 1'b1;
                r.status = ST_NO_MEM;
            end
            worst_lvl = SEV_OK;
            for (i = 0; i < tab_used; i++) begin
                if (tab_level[i] > worst_lvl) worst_lvl = tab_level[i];
            end
        end
        r.worst   = worst_lvl;
        r.active  = tab_used[ACTIVE_W-1:0];
        r.dropped = drop_cnt;
        return r;
    endfunction

    // Directed table builders
    function automatic void plan_cfg(input logic en);
        t_plan_row row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.enable = en;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_pub(input logic [KEY_W-1:0] key, input logic [SEV_W-1:0] sev,
                                     input logic [MS_W-1:0] stamp);
        t_plan_row row;
        row       = '0;
        row.key   = key;
        row.sev   = sev;
        row.stamp = stamp;
        plan_q.push_back(row);
    endfunction

    function automatic void plan_pin(input logic [KEY_W-1:0] key, input logic [SEV_W-1:0] sev,
                                     input logic [MS_W-1:0] stamp, input t_status st,
                                     input logic [SEV_W-1:0] wl, input logic [SLOT_W-1:0] sl,
                                     input logic [OCC_W-1:0] oc, input logic [MS_W-1:0] fs,
                                     input logic [ACTIVE_W-1:0] ac,
                                     input logic [OCC_W-1:0] dr);
        t_plan_row row;
        row             = '0;
        row.key         = key;
        row.sev         = sev;
        row.stamp       = stamp;
        row.pinned      = 1'b1;
        row.res.status  = st;
        row.res.worst   = wl;
        row.res.slot    = sl;
        row.res.occ     = oc;
        row.res.first   = fs;
        row.res.active  = ac;
        row.res.dropped = dr;
        plan_q.push_back(row);
    endfunction

    function automatic int pick_gap(input int idle_pct);
        return ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 9) : 0;
    endfunction

    // Offer one publish word. Called at a falling edge; returns at the falling
    // edge after the word was taken, with valid still high so a back-to-back
    // word follows without a bubble.
    task automatic push_word(input logic [KEY_W-1:0] key, input logic [SEV_W-1:0] sev,
                             input logic [MS_W-1:0] stamp, input int gap,
                             input bit pinned, input t_board_result res);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pin_valid = pinned;
        pin_result = res;
        in_ch.valid      <= 1'b1;
        in_ch.source_key <= key;
        in_ch.severity   <= sev;
        in_ch.time_ms    <= stamp;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    // Drop valid and hold until every awaited result has come back and the
    // pipeline has had time to empty
    task automatic settle_board();
        in_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Write the enable register; only called on an idle board
    task automatic write_board_enable(input logic en);
        cfg_ch.valid         <= 1'b1;
        cfg_ch.board_enabled <= en;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random publish words. Most keys come from a small pool so that rows get
    // matched, updated, cleared and the table fills up; the rest are empty
    // keys, full-width random keys and the illegal severity code.
    task automatic random_phase(input int n_words, input int idle_pct, input int clear_pct,
                                input int key_span);
        logic [KEY_W-1:0] key;
        logic [SEV_W-1:0] sev;
        logic [63:0]      stamp;
        t_board_result    none;
        int               roll;
        int               k;
        none = '0;
        for (k = 0; k < n_words; k++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) key = '0;
            else if (roll < 16) key = $urandom;
            else key = KEY_W'($urandom_range(1, key_span));
            roll = $urandom_range(0, 99);
            if (roll < 5) sev = SEV_BAD;
            else if (roll < 5 + clear_pct) sev = SEV_OK;
            else sev = ($urandom_range(0, 1) != 0) ? SEV_CRIT : SEV_WARN;
            stamp = {$urandom, $urandom};
            push_word(key, sev, stamp[MS_W-1:0], pick_gap(idle_pct), 1'b0, none);
        end
    endtask

    // Result sink: random stall bursts, their rate set per phase
    initial begin
        forever begin
            @(negedge clk);
            if ($urandom_range(0, 99) < sink_stall_pct) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // Sample all handshakes at the rising edge: predict on every accepted
    // publish word, track register writes, check every result word in order
    always @(posedge clk) begin : watch
        t_board_result exp_r;
        t_board_result got_r;
        if (rst_n) begin
            cycle_count++;
            if (cfg_ch.valid && cfg_ch.ready) board_on = cfg_ch.board_enabled;
            if (in_ch.valid && in_ch.ready) begin
                exp_r = predict_publish(in_ch.source_key, in_ch.severity, in_ch.time_ms);
                if (pin_valid) exp_r = pin_result;
                awaited_results.push_back(exp_r);
                tally_status[exp_r.status]++;
                words_in++;
            end
            if (out_ch.valid && out_ch.ready) begin
                got_r.status  = t_status'(out_ch.status);
                got_r.worst   = out_ch.worst_level;
                got_r.slot    = out_ch.slot_index;
                got_r.occ     = out_ch.occurrences;
                got_r.first   = out_ch.first_seen_ms;
                got_r.active  = out_ch.active_entries;
                got_r.dropped = out_ch.dropped_total;
                words_out++;
                if (awaited_results.size() == 0) begin
                    err_count++;
                    if (err_count <= REPORT_MAX)
                        $display("cycle %0d: result word with nothing awaited", cycle_count);
                end else begin
                    exp_r = awaited_results.pop_front();
                    if (got_r.status !== exp_r.status || got_r.worst !== exp_r.worst
                        || got_r.slot !== exp_r.slot || got_r.occ !== exp_r.occ
                        || got_r.first !== exp_r.first || got_r.active !== exp_r.active
                        || got_r.dropped !== exp_r.dropped) begin
                        err_count++;
                        if (err_count <= REPORT_MAX) begin
                            $display("cycle %0d: result %0d mismatch", cycle_count, words_out);
                            $display({"  exp st=%0d worst=%0d slot=%0d occ=%0d",
                                      " first=%0h act=%0d drop=%0d"},
                                     exp_r.status, exp_r.worst, exp_r.slot, exp_r.occ,
                                     exp_r.first, exp_r.active, exp_r.dropped);
                            $display({"  got st=%0d worst=%0d slot=%0d occ=%0d",
                                      " first=%0h act=%0d drop=%0d"},
                                     got_r.status, got_r.worst, got_r.slot, got_r.occ,
                                     got_r.first, got_r.active, got_r.dropped);
                        end
                    end
                end
            end
        end
    end

    // Watchdog: end a hung run
    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, awaited_results.size());
        $display("keyed_warning_board_tb failed");
        $finish;
    end

    initial begin : stimulus
        int r;
        int k;

        // Every input known from time zero
        rst_n                = 1'b0;
        in_ch.valid          = 1'b0;
        in_ch.source_key     = '0;
        in_ch.severity       = SEV_OK;
        in_ch.time_ms        = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.board_enabled = 1'b0;
        out_ch.ready         = 1'b0;
        for (k = 0; k < BOARD_DEPTH; k++) begin
            tab_key[k]   = '0;
            tab_level[k] = SEV_OK;
            tab_count[k] = '0;
            tab_first[k] = '0;
            tab_last[k]  = '0;
        end

        // Directed table. The board comes out of reset disabled.
        plan_pin(32'd1, SEV_WARN, 48'd0, ST_INVALID_STATE, SEV_OK, NO_SLOT, 0, 0, 0, 0);
        plan_cfg(1'b1);
        // empty key and illegal severity are rejected without touching the table
        plan_pin(32'd0, SEV_WARN, 48'd10, ST_INVALID_ARG, SEV_OK, NO_SLOT, 0, 0, 0, 0);
        plan_pin(32'd5, SEV_BAD, 48'd20, ST_INVALID_ARG, SEV_OK, NO_SLOT, 0, 0, 0, 0);
        // extremes of key and time on the first row
        plan_pin(32'hFFFF_FFFF, SEV_CRIT, 48'hFFFF_FFFF_FFFF, ST_OK, SEV_CRIT, 4'd0, 1,
                 48'hFFFF_FFFF_FFFF, 1, 0);
        plan_pin(32'd1, SEV_WARN, 48'd0, ST_OK, SEV_CRIT, 4'd1, 1, 0, 2, 0);
        // repeat hits on one key, then fill the table
        plan_pub(32'd1, SEV_CRIT, 48'd100);
        plan_pub(32'd1, SEV_WARN, 48'd200);
        for (k = 2; k < 8; k++) plan_pub(k, SEV_WARN, 48'd300 + k);
        // table full: dropped, counter advances
        plan_pin(32'd9, SEV_WARN, 48'd400, ST_NO_MEM, SEV_CRIT, NO_SLOT, 0, 0, 8, 1);
        plan_pub(32'd10, SEV_CRIT, 48'd410);
        // clear of an absent key, then removals at the head, middle and tail
        plan_pub(32'd9, SEV_OK, 48'd420);
        plan_pub(32'hFFFF_FFFF, SEV_OK, 48'd430);
        plan_pub(32'd4, SEV_OK, 48'd440);
        plan_pub(32'd7, SEV_OK, 48'd450);
        plan_cfg(1'b0);
        plan_pub(32'd2, SEV_CRIT, 48'd460);
        plan_cfg(1'b1);
        plan_pub(32'd0, SEV_OK, 48'd470);
        plan_pub(32'd2, SEV_BAD, 48'd480);
        // empty the table; the last clear leaves nothing behind
        plan_pub(32'd1, SEV_OK, 48'd501);
        plan_pub(32'd2, SEV_OK, 48'd502);
        plan_pub(32'd3, SEV_OK, 48'd503);
        plan_pub(32'd5, SEV_OK, 48'd505);
        plan_pin(32'd6, SEV_OK, 48'd506, ST_OK, SEV_OK, 4'd0, 0, 0, 0, 2);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        sink_stall_pct = 8;
        for (r = 0; r < plan_q.size(); r++) begin
            if (plan_q[r].is_cfg) begin
                settle_board();
                write_board_enable(plan_q[r].enable);
            end else begin
                push_word(plan_q[r].key, plan_q[r].sev, plan_q[r].stamp, pick_gap(20),
                          plan_q[r].pinned, plan_q[r].res);
            end
        end

        // Fill-heavy mix with idling on both sides; the sender holds off
        // halfway until every result is back
        settle_board();
        write_board_enable(1'b1);
        sink_stall_pct = 10;
        random_phase(70, 25, 15, 10);
        settle_board();
        random_phase(70, 25, 15, 10);

        // Disabled board: everything bounces
        settle_board();
        write_board_enable(1'b0);
        sink_stall_pct = 5;
        random_phase(20, 10, 25, 10);

        // Clear-heavy mix over a wider pool, sender idles, sink never stalls
        settle_board();
        write_board_enable(1'b1);
        sink_stall_pct = 0;
        random_phase(150, 12, 40, 14);

        // Closing stretch at full rate: no idling on either side
        settle_board();
        write_board_enable(1'b1);
        random_phase(140, 0, 25, 10);

        settle_board();
        $display({"covered %0d publish words: %0d ok, %0d invalid_state,",
                  " %0d invalid_arg, %0d no_mem"},
                 words_in, tally_status[ST_OK], tally_status[ST_INVALID_STATE],
                 tally_status[ST_INVALID_ARG], tally_status[ST_NO_MEM]);
        $display("board enabled and disabled, %0d result words checked, %0d mismatches",
                 words_out, err_count);
        if (err_count == 0 && awaited_results.size() == 0) begin
            $display("keyed_warning_board_tb passed");
        end else begin
            $display("keyed_warning_board_tb failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/kwb_pkg.sv
sv/kwb_if.sv
sv/kwb_front.sv
sv/kwb_queue.sv
sv/kwb_back.sv
sv/keyed_warning_board.sv
sv/kwb_checker.sv
sim/keyed_warning_board_tb.sv
